>>> rtl/acfr_pkg.sv
// shared types, constants and helpers for the ascii checksum frame receiver
// no dependencies; imported by every module of the block
package acfr_pkg;

  // field widths fixed by the stream formats
  localparam int CmdW      = 2;
  localparam int ByteW     = 8;
  localparam int RdIdxW    = 6;
  localparam int StatusW   = 3;
  localparam int StoreIdxW = 6;
  localparam int InTdataW  = 16;
  localparam int OutTdataW = 32;

  // configuration port
  localparam int CfgAddrW  = 2;

  localparam int DefaultBufferDepth = 64;

  // register reset values
  localparam logic [ByteW-1:0] StartCodeARst = 8'h06;
  localparam logic [ByteW-1:0] StartCodeBRst = 8'h05;
  localparam logic [ByteW-1:0] EndCodeARst   = 8'h03;
  localparam logic [ByteW-1:0] EndCodeBRst   = 8'h04;

  // ascii constants for hex digit decode
  localparam logic [ByteW-1:0] AsciiZero  = 8'h30;
  localparam logic [ByteW-1:0] AsciiNine  = 8'h39;
  localparam logic [ByteW-1:0] AsciiSeven = 8'h37;

  typedef enum logic [CmdW-1:0] {
    CMD_RX       = 2'd0,
    CMD_TX_BEGIN = 2'd1,
    CMD_TX_END   = 2'd2,
    CMD_READ     = 2'd3
  } cmd_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_START_A = 2'd0,
    CFG_START_B = 2'd1,
    CFG_END_A   = 2'd2,
    CFG_END_B   = 2'd3
  } cfg_reg_e;

  // write request from the controller to the frame store
  typedef struct packed {
    logic             we;          // write data at the index after the current one
    logic [ByteW-1:0] data;
    logic             first_we;    // also write slot 0
    logic [ByteW-1:0] first_data;
    logic             last_clr;    // clear the last slot
  } wr_req_t;

  // ascii hex digit decode, modulo 256
  function automatic logic [ByteW-1:0] hex_digit(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] r;
    if (c <= AsciiNine) begin
      r = c - AsciiZero;
    end else begin
      r = c - AsciiSeven;
    end
    return r;
  endfunction

endpackage

>>> rtl/acfr_ctrl.sv
// frame state machine, write index, running sum and configuration registers
// depends on acfr_pkg
module acfr_ctrl #(
  parameter int BufferDepth = acfr_pkg::DefaultBufferDepth,
  parameter int AddrW       = $clog2(BufferDepth)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [acfr_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [acfr_pkg::ByteW-1:0]    cfg_wdata_i,
  // accepted item
  input  logic                          accept_i,
  input  logic [acfr_pkg::CmdW-1:0]     cmd_i,
  input  logic [acfr_pkg::ByteW-1:0]    rx_byte_i,
  // values after this item
  output logic [acfr_pkg::StatusW-1:0]  status_o,
  output logic [acfr_pkg::ByteW-1:0]    sum_o,
  output logic [AddrW-1:0]              index_o,
  output logic                          good_o,
  // frame store write
  output logic [AddrW-1:0]              waddr_o,
  output acfr_pkg::wr_req_t             wr_o
);
  import acfr_pkg::*;

  typedef enum logic [StatusW-1:0] {
    ST_WAIT = 3'd0,
    ST_BODY = 3'd1,
    ST_CHKH = 3'd2,
    ST_CHKL = 3'd3,
    ST_GOOD = 3'd4,
    ST_TX   = 3'd5,
    ST_ERR  = 3'd6
  } state_e;

  localparam logic [AddrW-1:0] LastIdx = AddrW'(BufferDepth - 1);

  state_e           state_q, state_d;
  logic [AddrW-1:0] idx_q, idx_d, idx_inc;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] start_a_q, start_b_q, end_a_q, end_b_q;
  logic [ByteW-1:0] hex;
  logic             is_start, is_end, good;
  wr_req_t          wr;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_a_q <= StartCodeARst;
      start_b_q <= StartCodeBRst;
      end_a_q   <= EndCodeARst;
      end_b_q   <= EndCodeBRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_START_A: start_a_q <= cfg_wdata_i;
        CFG_START_B: start_b_q <= cfg_wdata_i;
        CFG_END_A:   end_a_q   <= cfg_wdata_i;
        CFG_END_B:   end_b_q   <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  // byte classification
  assign idx_inc  = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
  assign is_start = (rx_byte_i == start_a_q) || (rx_byte_i == start_b_q);
  assign is_end   = (rx_byte_i == end_a_q) || (rx_byte_i == end_b_q);
  assign hex      = hex_digit(rx_byte_i);

  // next state for one item
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    good    = 1'b0;
    wr      = '0;
    unique case (cmd_e'(cmd_i))
      CMD_RX: begin
        if (state_q != ST_TX) begin
          idx_d   = idx_inc;
          wr.we   = 1'b1;
          wr.data = rx_byte_i;
          unique case (state_q)
            ST_WAIT: begin
              if (is_start) begin
                state_d       = ST_BODY;
                wr.first_we   = 1'b1;
                wr.first_data = rx_byte_i;
                idx_d         = '0;
                sum_d         = rx_byte_i;
              end
            end
            ST_BODY: begin
              sum_d = sum_q + rx_byte_i;
              if (is_end) begin
                wr.data = '0;
                state_d = ST_CHKH;
              end
            end
            ST_CHKH: begin
              wr.data = '0;
              state_d = (hex == {4'h0, sum_q[7:4]}) ? ST_CHKL : ST_WAIT;
            end
            ST_CHKL: begin
              wr.data     = '0;
              wr.last_clr = 1'b1;
              if (hex == {4'h0, sum_q[3:0]}) begin
                state_d = ST_GOOD;
                good    = 1'b1;
              end else begin
                state_d = ST_WAIT;
              end
            end
            default: begin
              // good, error or unused code: restart
              state_d = ST_WAIT;
              idx_d   = '0;
            end
          endcase
        end
      end
      CMD_TX_BEGIN: state_d = ST_TX;
      CMD_TX_END: begin
        if (state_q == ST_TX) begin
          state_d = ST_WAIT;
        end
      end
      default: ;
    endcase
  end

  // state registers advance on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WAIT;
      idx_q   <= '0;
      sum_q   <= '0;
    end else if (accept_i) begin
      state_q <= state_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
    end
  end

  assign status_o = state_d;
  assign sum_o    = sum_d;
  assign index_o  = idx_d;
  assign good_o   = good;
  assign waddr_o  = idx_inc;

  // writes only on an accepted beat
  always_comb begin
    wr_o = wr;
    if (!accept_i) begin
      wr_o.we       = 1'b0;
      wr_o.first_we = 1'b0;
      wr_o.last_clr = 1'b0;
    end
  end

endmodule

>>> rtl/acfr_store.sv
// frame buffer: memory with per-entry valid bits, slot 0 and last slot in flops
// depends on acfr_pkg
module acfr_store #(
  parameter int BufferDepth = acfr_pkg::DefaultBufferDepth,
  parameter int AddrW       = $clog2(BufferDepth)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // write side
  input  logic [AddrW-1:0]            waddr_i,
  input  acfr_pkg::wr_req_t           wr_i,
  // read side, sampled on an accepted beat
  input  logic                        accept_i,
  input  logic                        rd_en_i,
  input  logic [acfr_pkg::RdIdxW-1:0] raddr_i,
  output logic [acfr_pkg::ByteW-1:0]  rdata_o
);
  import acfr_pkg::*;

  localparam int WideW = (AddrW > RdIdxW) ? AddrW : RdIdxW;
  localparam logic [AddrW-1:0] LastIdx = AddrW'(BufferDepth - 1);

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_MEM,
    RD_FIRST,
    RD_LAST
  } rd_kind_e;

  logic [ByteW-1:0]       mem [BufferDepth];
  logic [BufferDepth-1:0] valid_q;
  logic [ByteW-1:0]       first_q, last_q, rd_mem_q;
  rd_kind_e               rd_kind_q, rd_kind_d;
  logic [WideW-1:0]       raddr_wide;
  logic [AddrW-1:0]       raddr;
  logic                   in_range, mem_we;

  assign mem_we = wr_i.we && (waddr_i != '0) && (waddr_i != LastIdx);

  // middle slots live in the memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr_i] <= wr_i.data;
    end
  end

  // valid bits and the two fixed slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      first_q <= '0;
      last_q  <= '0;
    end else begin
      if (mem_we) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (wr_i.first_we) begin
        first_q <= wr_i.first_data;
      end else if (wr_i.we && (waddr_i == '0)) begin
        first_q <= wr_i.data;
      end
      if (wr_i.last_clr) begin
        last_q <= '0;
      end else if (wr_i.we && (waddr_i == LastIdx)) begin
        last_q <= wr_i.data;
      end
    end
  end

  // read address decode
  assign raddr_wide = WideW'(raddr_i);
  assign raddr      = raddr_wide[AddrW-1:0];
  assign in_range   = (32'(raddr_i) < BufferDepth);

  always_comb begin
    rd_kind_d = RD_ZERO;
    if (rd_en_i && in_range) begin
      if (raddr == '0) begin
        rd_kind_d = RD_FIRST;
      end else if (raddr == LastIdx) begin
        rd_kind_d = RD_LAST;
      end else if (valid_q[raddr]) begin
        rd_kind_d = RD_MEM;
      end
    end
  end

  // registered memory read
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd_mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_kind_q <= RD_ZERO;
    end else if (accept_i) begin
      rd_kind_q <= rd_kind_d;
    end
  end

  // fixed slots only change on a later beat, which replaces this result
  always_comb begin
    unique case (rd_kind_q)
      RD_MEM:   rdata_o = rd_mem_q;
      RD_FIRST: rdata_o = first_q;
      RD_LAST:  rdata_o = last_q;
      default:  rdata_o = '0;
    endcase
  end

endmodule

>>> rtl/ascii_checksum_frame_receiver_top.sv
// top level of the ascii checksum frame receiver: stream ports and result register
// depends on acfr_pkg, acfr_ctrl and acfr_store
//
// Receives UART bytes and transmit begin/end events on the slave stream and
// returns exactly one result beat per input beat. Each beat is handled in the
// cycle it is accepted: the frame state, index, sum and buffer write settle
// in one pass of compare/add logic and land in the result register, so a new
// beat is taken every cycle as long as the master side takes results. The
// buffer is a memory of BUFFER_DEPTH bytes with one read registered per beat;
// after reset it reads as zero with no clearing pass. Configuration writes
// take effect at the next edge and are meant to happen only while no beat is
// in flight.
module ascii_checksum_frame_receiver_top #(
  parameter int BUFFER_DEPTH = acfr_pkg::DefaultBufferDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [acfr_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [acfr_pkg::ByteW-1:0]      cfg_wdata_i,
  // input stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // command[1:0], rx_byte[9:2], read_index[15:10]
  input  logic [acfr_pkg::InTdataW-1:0]   s_axis_tdata_i,
  // result stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // status[2:0], sum_low[10:3], store_index[16:11], read_data[24:17],
  // frame_good[25], zero[31:26]
  output logic [acfr_pkg::OutTdataW-1:0]  m_axis_tdata_o
);
  import acfr_pkg::*;

  localparam int AddrW = $clog2(BUFFER_DEPTH);
  localparam int WideW = (AddrW > StoreIdxW) ? AddrW : StoreIdxW;

  logic                 accept;
  logic [CmdW-1:0]      cmd;
  logic [ByteW-1:0]     rx_byte;
  logic [RdIdxW-1:0]    read_index;

  logic [StatusW-1:0]   status_d;
  logic [ByteW-1:0]     sum_d;
  logic [AddrW-1:0]     index_d;
  logic                 good_d;
  logic [AddrW-1:0]     waddr;
  wr_req_t              wr;
  logic [ByteW-1:0]     read_data;
  logic [WideW-1:0]     index_wide;

  logic                 out_valid_q;
  logic [StatusW-1:0]   status_q;
  logic [ByteW-1:0]     sum_q;
  logic [StoreIdxW-1:0] store_idx_q;
  logic                 good_q;

  // input beat fields
  assign cmd        = s_axis_tdata_i[1:0];
  assign rx_byte    = s_axis_tdata_i[9:2];
  assign read_index = s_axis_tdata_i[15:10];

  // take a beat when the result register is free or drains this cycle
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  acfr_ctrl #(
    .BufferDepth(BUFFER_DEPTH),
    .AddrW      (AddrW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .cmd_i      (cmd),
    .rx_byte_i  (rx_byte),
    .status_o   (status_d),
    .sum_o      (sum_d),
    .index_o    (index_d),
    .good_o     (good_d),
    .waddr_o    (waddr),
    .wr_o       (wr)
  );

  acfr_store #(
    .BufferDepth(BUFFER_DEPTH),
    .AddrW      (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .waddr_i (waddr),
    .wr_i    (wr),
    .accept_i(accept),
    .rd_en_i (cmd == CMD_READ),
    .raddr_i (read_index),
    .rdata_o (read_data)
  );

  assign index_wide = WideW'(index_d);

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      sum_q       <= sum_d;
      store_idx_q <= index_wide[StoreIdxW-1:0];
      good_q      <= good_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, good_q, read_data, store_idx_q, sum_q, status_q};

endmodule
